// ===== hdl/rotated_rect_row_address_gen_macros.svh =====
// assertion macros shared by the rectangle address generator modules
`ifndef ROTATED_RECT_ROW_ADDRESS_GEN_MACROS_SVH
`define ROTATED_RECT_ROW_ADDRESS_GEN_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while rst is high
`define RRAG_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst is high
`define RRAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rrag_pkg.sv =====
// shared widths, register codes and control types for the rectangle address generator
`timescale 1ns / 1ps

package rrag_pkg;

  // request fields
  localparam int X_W     = 12;
  localparam int Y_W     = 12;
  localparam int W_W     = 13;
  localparam int H_W     = 7;
  localparam int COLOR_W = 8;

  // row result fields
  localparam int OFFSET_W = 27;
  localparam int COUNT_W  = 13;

  // configuration registers
  localparam int SW_W       = 13;
  localparam int SH_W       = 13;
  localparam int ROT_W      = 2;
  localparam int BPP_W      = 3;
  localparam int LL_W       = 15;
  localparam int YOFF_W     = 13;
  localparam int VH_W       = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // datapath internals
  localparam int DIVD_W    = 14;             // py + y_offset
  localparam int ROW_W     = DIVD_W + 1;     // wrapped row, unwrapped rows grow by one bit
  localparam int DIV_STEPS = DIVD_W;         // one quotient bit per cycle
  localparam int DIV_CNT_W = 4;
  localparam int PXB_W     = SW_W + BPP_W;   // px times pixel size in bytes
  localparam int PROD_W    = ROW_W + LL_W;   // row * line_length_bytes

  // register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH      = 3'd0,
    REG_SCREEN_HEIGHT     = 3'd1,
    REG_ROTATION          = 3'd2,
    REG_PIXEL_BYTES       = 3'd3,
    REG_LINE_LENGTH_BYTES = 3'd4,
    REG_Y_OFFSET          = 3'd5,
    REG_VIRTUAL_HEIGHT    = 3'd6
  } cfg_reg_t;

  // rotation codes
  typedef enum logic [ROT_W-1:0] {
    ROT_NONE = 2'd0,
    ROT_90   = 2'd1,
    ROT_180  = 2'd2,
    ROT_270  = 2'd3
  } rot_t;

  // register values after reset
  localparam logic [SW_W-1:0]   RST_SCREEN_WIDTH    = 13'd640;
  localparam logic [SH_W-1:0]   RST_SCREEN_HEIGHT   = 13'd480;
  localparam logic [BPP_W-1:0]  RST_PIXEL_BYTES     = 3'd2;
  localparam logic [LL_W-1:0]   RST_LINE_LENGTH     = 15'd1280;
  localparam logic [YOFF_W-1:0] RST_Y_OFFSET        = 13'd0;
  localparam logic [VH_W-1:0]   RST_VIRTUAL_HEIGHT  = 14'd480;

  // controller to datapath
  typedef struct packed {
    logic idle;      // free to take a request
    logic load_req;  // request transfer this cycle
    logic clip;      // register clipped size
    logic rotate;    // register physical rectangle
    logic prep;      // start the row wrap and offset base
    logic div_step;  // one remainder step
    logic emit;      // load one row into the output register
  } rrag_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_valid;
    logic reject_req;   // origin off screen, empty size, bad colour or too tall
    logic reject_rows;  // too many physical rows after rotation
    logic no_wrap;      // virtual height of zero
    logic div_last;     // final remainder step
    logic out_free;     // output register can take a row
    logic last;         // one row left
  } rrag_sts_t;

endpackage

// ===== hdl/rrag_if.sv =====
// handshake channels of the rectangle address generator: request, row result, configuration
`timescale 1ns / 1ps

interface rrag_req_if;
  import rrag_pkg::*;
  logic               valid;
  logic               ready;
  logic [X_W-1:0]     rect_x;
  logic [Y_W-1:0]     rect_y;
  logic [W_W-1:0]     rect_width;
  logic [H_W-1:0]     rect_height;
  logic [COLOR_W-1:0] fill_color;

  modport source (output valid, rect_x, rect_y, rect_width, rect_height, fill_color,
                  input ready);
  modport sink   (input valid, rect_x, rect_y, rect_width, rect_height, fill_color,
                  output ready);
endinterface

interface rrag_row_if;
  import rrag_pkg::*;
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] row_byte_offset;
  logic [COUNT_W-1:0]  pixel_count;
  logic [COLOR_W-1:0]  row_color;
  logic                last_row;

  modport source (output valid, row_byte_offset, pixel_count, row_color, last_row,
                  input ready);
  modport sink   (input valid, row_byte_offset, pixel_count, row_color, last_row,
                  output ready);
endinterface

interface rrag_cfg_if;
  import rrag_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rotated_rect_row_address_gen.sv =====
// top level of the rotated rectangle fill row address generator
`timescale 1ns / 1ps
// Usage
//   req  : fill request transfer (rect_x, rect_y, rect_width, rect_height, fill_color),
//          taken only while no earlier request is still being worked on.
//   rows : one transfer per physical row: row_byte_offset, pixel_count, row_color,
//          last_row set on the final row. Rejected requests give no rows at all.
//   cfg  : register writes (index, data), always ready; write only while idle.
// Timing
//   Check and clip, then rotate, run in their own states after the request transfer. The first
//   row's wrap (row plus y_offset modulo virtual_height) runs through a one bit per
//   cycle remainder unit, skipped when virtual_height is zero. Rows then leave at one
//   per cycle while rows.ready is high; a rejected request frees the block from the
//   check or the row-count test after rotation. The next request is taken as soon as
//   the final row sits in the output register.
// Reset (rst, synchronous): registers return to 640x480, no rotation, 2 bytes per
//   pixel, 1280 byte lines, offset 0, virtual height 480; no row is pending.
// Stall: a held rows.ready freezes the output register and row sequencing.
module rotated_rect_row_address_gen #(
  parameter int MAX_ROWS    = 64,
  parameter int COLOR_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst,
  rrag_req_if.sink   req,
  rrag_row_if.source rows,
  rrag_cfg_if.sink   cfg
);
  import rrag_pkg::*;

  rrag_cmd_t cmd;
  rrag_sts_t sts;

  // sequencer
  rrag_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // datapath
  rrag_dpath #(
    .MAX_ROWS    (MAX_ROWS),
    .COLOR_COUNT (COLOR_COUNT)
  ) u_dpath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rows (rows),
    .cfg  (cfg),
    .cmd  (cmd),
    .sts  (sts)
  );

endmodule

// ===== hdl/rrag_ctrl.sv =====
// sequencing state machine of the rectangle address generator
`timescale 1ns / 1ps
`include "rotated_rect_row_address_gen_macros.svh"

module rrag_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  rrag_pkg::rrag_sts_t sts,
  output rrag_pkg::rrag_cmd_t cmd
);
  import rrag_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_ROT   = 6'b000100,
    S_PREP  = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.reject_req) begin
          state_next = S_IDLE;
        end else begin
          cmd.clip   = 1'b1;
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        cmd.rotate = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        if (sts.reject_rows) begin
          state_next = S_IDLE;
        end else begin
          cmd.prep   = 1'b1;
          state_next = sts.no_wrap ? S_EMIT : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // checks
  `RRAG_ASSERT_IMPLIES(a_emit_needs_room, cmd.emit, sts.out_free, "row loaded into a full output register")
  `RRAG_ASSERT_NEXT(a_last_row_frees, cmd.emit && sts.last, cmd.idle, "not idle after the final row")
  `RRAG_ASSERT_NEXT(a_one_request_at_a_time, cmd.load_req, !cmd.idle, "second request taken while busy")

endmodule

// ===== hdl/rrag_dpath.sv =====
// datapath of the rectangle address generator: registers, clip, rotation, row wrap, offsets
`timescale 1ns / 1ps
`include "rotated_rect_row_address_gen_macros.svh"

module rrag_dpath #(
  parameter int MAX_ROWS    = 64,
  parameter int COLOR_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst,
  rrag_req_if.sink            req,
  rrag_row_if.source          rows,
  rrag_cfg_if.sink            cfg,
  input  rrag_pkg::rrag_cmd_t cmd,
  output rrag_pkg::rrag_sts_t sts
);
  import rrag_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);

  // configuration registers
  logic [SW_W-1:0]   screen_width;
  logic [SH_W-1:0]   screen_height;
  rot_t              rotation;
  logic [BPP_W-1:0]  pixel_bytes;
  logic [LL_W-1:0]   line_length_bytes;
  logic [YOFF_W-1:0] y_offset;
  logic [VH_W-1:0]   virtual_height;

  // request and working registers
  logic [X_W-1:0]     rx;
  logic [Y_W-1:0]     ry;
  logic [W_W-1:0]     rw;
  logic [H_W-1:0]     rh;
  logic [COLOR_W-1:0] color;
  logic [SW_W-1:0]    cw;
  logic [H_W-1:0]     ch;
  logic [SW_W-1:0]    px;
  logic [SW_W-1:0]    py;
  logic [COUNT_W-1:0] pw;
  logic [SW_W-1:0]    ph;
  logic [PXB_W-1:0]   pxb;
  logic [ROW_W-1:0]   r;
  logic [DIVD_W-1:0]  dq;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [RW-1:0]      rows_left;

  // output register
  logic                out_valid;
  logic [OFFSET_W-1:0] out_offset;
  logic [COUNT_W-1:0]  out_count;
  logic [COLOR_W-1:0]  out_color;
  logic                out_last;

  // combinational terms
  logic [DIVD_W-1:0]  x_end;
  logic [DIVD_W-1:0]  y_end;
  logic [SW_W-1:0]    cw_clip;
  logic [H_W-1:0]     ch_clip;
  logic [SW_W-1:0]    sh_rem;
  logic [SW_W-1:0]    sw_rem;
  logic [SW_W-1:0]    px_next;
  logic [SW_W-1:0]    py_next;
  logic [COUNT_W-1:0] pw_next;
  logic [SW_W-1:0]    ph_next;
  logic [DIVD_W-1:0]  divd;
  logic [ROW_W-1:0]   trial;
  logic [ROW_W-1:0]   vh_ext;
  logic [ROW_W-1:0]   r_inc;
  logic [PROD_W-1:0]  prod;
  logic [OFFSET_W-1:0] offset_next;

  // configuration writes, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width      <= RST_SCREEN_WIDTH;
      screen_height     <= RST_SCREEN_HEIGHT;
      rotation          <= ROT_NONE;
      pixel_bytes       <= RST_PIXEL_BYTES;
      line_length_bytes <= RST_LINE_LENGTH;
      y_offset          <= RST_Y_OFFSET;
      virtual_height    <= RST_VIRTUAL_HEIGHT;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SCREEN_WIDTH:      screen_width      <= cfg.data[SW_W-1:0];
        REG_SCREEN_HEIGHT:     screen_height     <= cfg.data[SH_W-1:0];
        REG_ROTATION:          rotation          <= rot_t'(cfg.data[ROT_W-1:0]);
        REG_PIXEL_BYTES:       pixel_bytes       <= cfg.data[BPP_W-1:0];
        REG_LINE_LENGTH_BYTES: line_length_bytes <= cfg.data[LL_W-1:0];
        REG_Y_OFFSET:          y_offset          <= cfg.data[YOFF_W-1:0];
        REG_VIRTUAL_HEIGHT:    virtual_height    <= cfg.data[VH_W-1:0];
        default: ;
      endcase
    end
  end

  // request handshake
  assign req.ready     = cmd.idle;
  assign sts.req_valid = req.valid;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      rx    <= req.rect_x;
      ry    <= req.rect_y;
      rw    <= req.rect_width;
      rh    <= req.rect_height;
      color <= req.fill_color;
    end
  end

  // rejection and clipping to the logical screen
  assign x_end   = DIVD_W'(rx) + DIVD_W'(rw);
  assign y_end   = DIVD_W'(ry) + DIVD_W'(rh);
  assign cw_clip = (x_end > DIVD_W'(screen_width)) ? screen_width - SW_W'(rx) : rw;
  assign ch_clip = (y_end > DIVD_W'(screen_height)) ?
                   H_W'(screen_height - SH_W'(ry)) : rh;

  assign sts.reject_req = (SW_W'(rx) >= screen_width) || (SH_W'(ry) >= screen_height) ||
                          (rw == '0) || (rh == '0) ||
                          ({1'b0, color} >= (COLOR_W + 1)'(COLOR_COUNT)) ||
                          (rh > H_W'(MAX_ROWS));

  always_ff @(posedge clk) begin
    if (cmd.clip) begin
      cw <= cw_clip;
      ch <= ch_clip;
    end
  end

  // rotation into physical coordinates
  assign sh_rem = screen_height - SH_W'(ry) - SH_W'(ch);
  assign sw_rem = screen_width - SW_W'(rx) - cw;

  always_comb begin
    case (rotation)
      ROT_90: begin
        px_next = sh_rem;
        py_next = SW_W'(rx);
        pw_next = COUNT_W'(ch);
        ph_next = cw;
      end
      ROT_180: begin
        px_next = sw_rem;
        py_next = sh_rem;
        pw_next = cw;
        ph_next = SW_W'(ch);
      end
      ROT_270: begin
        px_next = SW_W'(ry);
        py_next = sw_rem;
        pw_next = COUNT_W'(ch);
        ph_next = cw;
      end
      default: begin
        // no rotation
        px_next = SW_W'(rx);
        py_next = SW_W'(ry);
        pw_next = cw;
        ph_next = SW_W'(ch);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rotate) begin
      px <= px_next;
      py <= py_next;
      pw <= pw_next;
      ph <= ph_next;
    end
  end

  assign sts.reject_rows = ph > SW_W'(MAX_ROWS);
  assign sts.no_wrap     = virtual_height == '0;

  // first row modulo virtual height: restoring remainder, one bit a cycle
  assign divd   = DIVD_W'(py) + DIVD_W'(y_offset);
  assign vh_ext = {1'b0, virtual_height};
  assign trial  = {r[DIVD_W-1:0], dq[DIVD_W-1]};

  assign sts.div_last = div_cnt == DIV_CNT_W'(1);

  // per row: step the wrapped row, multiply by line length
  assign r_inc       = r + ROW_W'(1);
  assign prod        = PROD_W'(r) * PROD_W'(line_length_bytes);
  assign offset_next = OFFSET_W'(pxb) + prod[OFFSET_W-1:0];

  assign sts.last = rows_left == RW'(1);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      pxb       <= PXB_W'(px) * PXB_W'(pixel_bytes);
      r         <= sts.no_wrap ? ROW_W'(divd) : '0;
      dq        <= divd;
      div_cnt   <= DIV_CNT_W'(DIV_STEPS);
      rows_left <= ph[RW-1:0];
    end else if (cmd.div_step) begin
      r       <= (trial >= vh_ext) ? trial - vh_ext : trial;
      dq      <= dq << 1;
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end else if (cmd.emit) begin
      r         <= (!sts.no_wrap && (r_inc == vh_ext)) ? '0 : r_inc;
      rows_left <= rows_left - RW'(1);
    end
  end

  // output register
  assign sts.out_free = !out_valid || rows.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rows.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_offset <= offset_next;
      out_count  <= pw;
      out_color  <= color;
      out_last   <= sts.last;
    end
  end

  assign rows.valid           = out_valid;
  assign rows.row_byte_offset = out_offset;
  assign rows.pixel_count     = out_count;
  assign rows.row_color       = out_color;
  assign rows.last_row        = out_last;

  // checks
  `RRAG_ASSERT_IMPLIES(a_rem_below_divisor, cmd.div_step, r < vh_ext, "remainder not below virtual height")
  `RRAG_ASSERT_IMPLIES(a_row_wrapped, cmd.emit && !sts.no_wrap, r < vh_ext, "row beyond wrap point")
  `RRAG_ASSERT_IMPLIES(a_rows_remain, cmd.emit, rows_left != '0, "row emitted with none left")

endmodule
